>>> hw/rtl/cw_keyed_tone_generator_assert.svh
// Assertion macros shared by the tone generator modules.
`ifndef CW_KEYED_TONE_GENERATOR_ASSERT_SVH
`define CW_KEYED_TONE_GENERATOR_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define CWKTG_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define CWKTG_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hw/rtl/cwktg_pkg.sv
package cwktg_pkg;

    // Sine table resolution in bits of phase, and the longest symbol.
    localparam int SINE_TABLE_BITS    = 10;
    localparam int MAX_SYMBOL_SAMPLES = 4096;

    localparam int FRAC_BITS = SINE_TABLE_BITS - 2;
    localparam int LUT_DEPTH = 2 ** FRAC_BITS;

    // Field and register widths.
    localparam int PHASE_W    = 32;
    localparam int VOLUME_W   = 7;
    localparam int SPB_W      = 13;
    localparam int RAMP_LEN_W = 6;
    localparam int RAMP_STEP_W = 16;
    localparam int SAMPLE_W   = 8;
    localparam int MAG_W      = 17;
    localparam int SINE_W     = MAG_W + 1;
    localparam int GAIN_W     = 17;
    localparam int PROD1_W    = 34;

    // Symbol position counter and the width used to compare lengths.
    localparam int POS_W = $clog2(MAX_SYMBOL_SAMPLES);
    localparam int CNT_W = POS_W + 1;
    localparam int CMP_W = (CNT_W > SPB_W) ? CNT_W : SPB_W;

    // Ramp angle: a 0.16 half-cycle fraction becomes a cycle phase by << 15.
    localparam int RAMP_SHIFT  = 15;
    localparam int RAMP_PROD_W = PHASE_W - RAMP_SHIFT;
    localparam logic [PHASE_W-1:0] QUARTER_PHASE = 32'h4000_0000;

    localparam logic [MAG_W-1:0]    SINE_ONE   = 17'd65536;
    localparam logic [SAMPLE_W-1:0] SAMPLE_MID = 8'h80;

    // Configuration port.
    localparam int PADDR_W    = 5;
    localparam int APB_DATA_W = 32;
    localparam int REG_IDX_W  = PADDR_W - 2;

    localparam logic [REG_IDX_W-1:0] REG_PHASE_STEP      = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_VOLUME          = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_SAMPLES_PER_BIT = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_RAMP_SAMPLES    = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_RAMP_STEP       = 3'd4;

    localparam logic [VOLUME_W-1:0]    VOLUME_RST    = 7'd100;
    localparam logic [SPB_W-1:0]       SPB_RST       = 13'd400;
    localparam logic [RAMP_LEN_W-1:0]  RAMP_LEN_RST  = 6'd4;
    localparam logic [RAMP_STEP_W-1:0] RAMP_STEP_RST = 16'd16384;

    typedef struct packed {
        logic [PHASE_W-1:0]     phase_step;
        logic [VOLUME_W-1:0]    volume;
        logic [SPB_W-1:0]       samples_per_bit;
        logic [RAMP_LEN_W-1:0]  ramp_samples;
        logic [RAMP_STEP_W-1:0] ramp_step;
    } t_cfg;

    // Commands from the sequencer to the datapath.
    typedef struct packed {
        logic             start;
        logic             zero_phase;
        logic [POS_W-1:0] pos;
        logic             lut;
        logic             ramp_on;
        logic             rise;
        logic             mul;
        logic             load_out;
        logic             use_sine;
        logic             sym_end;
    } t_dp_cmd;

    typedef logic [MAG_W-1:0] t_sine_lut [LUT_DEPTH];

    // Quarter-wave polynomial sine in Q16, evaluated once at elaboration.
    function automatic t_sine_lut build_sine_lut();
        t_sine_lut lut;
        longint unsigned t;
        longint unsigned t2;
        longint unsigned p;
        longint unsigned s;
        for (int i = 0; i < LUT_DEPTH; i++) begin
            t  = 64'(i) << (18 - SINE_TABLE_BITS);
            t2 = (t * t) >> 16;
            p  = 64'd42048 - ((64'd4640 * t2) >> 16);
            p  = 64'd102944 - ((p * t2) >> 16);
            s  = (t * p) >> 16;
            if (s > 64'd65536) begin
                s = 64'd65536;
            end
            lut[i] = MAG_W'(s);
        end
        return lut;
    endfunction

    localparam t_sine_lut SINE_LUT = build_sine_lut();

    // Signed Q16 sine of a 0.32 cycle phase, by quadrant mirroring of the table.
    function automatic logic signed [SINE_W-1:0] sine_q16(input logic [PHASE_W-1:0] phase);
        logic [SINE_TABLE_BITS-1:0] idx;
        logic [1:0]                 quad;
        logic [FRAC_BITS-1:0]       frac;
        logic [FRAC_BITS-1:0]       frac_mirror;
        logic [MAG_W-1:0]           mag;
        idx         = phase[PHASE_W-1 -: SINE_TABLE_BITS];
        quad        = idx[SINE_TABLE_BITS-1 -: 2];
        frac        = idx[FRAC_BITS-1:0];
        frac_mirror = ~frac + 1'b1;
        if (quad[0]) begin
            if (frac == '0) begin
                mag = SINE_ONE;
            end else begin
                mag = SINE_LUT[frac_mirror];
            end
        end else begin
            mag = SINE_LUT[frac];
        end
        return quad[1] ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
    endfunction

endpackage

>>> hw/rtl/cwktg_key_if.sv
interface cwktg_key_if;
    logic valid;
    logic ready;
    logic key_down;
    logic restart;

    modport source (output valid, output key_down, output restart, input ready);
    modport sink   (input valid, input key_down, input restart, output ready);
endinterface

>>> hw/rtl/cwktg_smp_if.sv
interface cwktg_smp_if;
    import cwktg_pkg::*;

    logic                valid;
    logic                ready;
    logic [SAMPLE_W-1:0] sample;
    logic                symbol_end;

    modport source (output valid, output sample, output symbol_end, input ready);
    modport sink   (input valid, input sample, input symbol_end, output ready);
endinterface

>>> hw/rtl/cwktg_regs.sv
module cwktg_regs (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [cwktg_pkg::PADDR_W-1:0]      paddr,
    input  logic [cwktg_pkg::APB_DATA_W-1:0]   pwdata,
    output logic [cwktg_pkg::APB_DATA_W-1:0]   prdata,
    output logic                               pready,
    output cwktg_pkg::t_cfg                    o_cfg
);
    import cwktg_pkg::*;

    t_cfg                 r_cfg;
    logic                 w_wr;
    logic [REG_IDX_W-1:0] w_idx;

    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite && pready;
    assign w_idx  = paddr[PADDR_W-1:2];
    assign o_cfg  = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.phase_step      <= '0;
            r_cfg.volume          <= VOLUME_RST;
            r_cfg.samples_per_bit <= SPB_RST;
            r_cfg.ramp_samples    <= RAMP_LEN_RST;
            r_cfg.ramp_step       <= RAMP_STEP_RST;
        end else if (w_wr) begin
            unique case (w_idx)
                REG_PHASE_STEP:      r_cfg.phase_step      <= pwdata[PHASE_W-1:0];
                REG_VOLUME:          r_cfg.volume          <= pwdata[VOLUME_W-1:0];
                REG_SAMPLES_PER_BIT: r_cfg.samples_per_bit <= pwdata[SPB_W-1:0];
                REG_RAMP_SAMPLES:    r_cfg.ramp_samples    <= pwdata[RAMP_LEN_W-1:0];
                REG_RAMP_STEP:       r_cfg.ramp_step       <= pwdata[RAMP_STEP_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        unique case (w_idx)
            REG_PHASE_STEP:      prdata = APB_DATA_W'(r_cfg.phase_step);
            REG_VOLUME:          prdata = APB_DATA_W'(r_cfg.volume);
            REG_SAMPLES_PER_BIT: prdata = APB_DATA_W'(r_cfg.samples_per_bit);
            REG_RAMP_SAMPLES:    prdata = APB_DATA_W'(r_cfg.ramp_samples);
            REG_RAMP_STEP:       prdata = APB_DATA_W'(r_cfg.ramp_step);
            default:             prdata = '0;
        endcase
    end

endmodule

>>> hw/rtl/cwktg_ctrl.sv
`include "cw_keyed_tone_generator_assert.svh"

module cwktg_ctrl (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  cwktg_pkg::t_cfg      i_cfg,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  logic                 i_key_down,
    input  logic                 i_restart,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output cwktg_pkg::t_dp_cmd   o_cmd
);
    import cwktg_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_LUT  = 4'b0010,
        S_MUL  = 4'b0100,
        S_OUT  = 4'b1000
    } t_state;

    t_state           r_state;
    t_state           n_state;
    logic             r_out_valid;
    logic [POS_W-1:0] r_pos;
    logic [POS_W-1:0] n_pos;
    logic             r_latched;
    logic             n_latched;
    logic             r_first;
    logic             n_first;
    logic             r_prev;
    logic             n_prev;
    logic             r_ramp_on;
    logic             n_ramp_on;
    logic             r_use_sine;
    logic             n_use_sine;
    logic             r_sym_end;
    logic             n_sym_end;

    logic             w_accept;
    logic             w_out_free;
    logic [POS_W-1:0] w_eff_pos;
    logic             w_eff_prev;
    logic             w_eff_first;
    logic             w_sym_start;
    logic             w_first_now;
    logic [CMP_W-1:0] w_len;
    logic [CMP_W-1:0] w_pos_next;

    assign o_in_ready  = (r_state == S_IDLE);
    assign w_accept    = i_in_valid && o_in_ready;
    assign w_out_free  = !r_out_valid || i_out_ready;
    assign o_out_valid = r_out_valid;

    // Symbol tracking for the item being accepted; restart applies first.
    always_comb begin
        w_eff_pos   = i_restart ? '0 : r_pos;
        w_eff_prev  = i_restart ? 1'b0 : r_prev;
        w_eff_first = i_restart ? 1'b1 : r_first;
        w_sym_start = (w_eff_pos == '0);
        n_latched   = w_sym_start ? i_key_down : r_latched;
        n_prev      = w_sym_start ? i_key_down : w_eff_prev;
        w_first_now = (w_sym_start && (i_key_down != w_eff_prev)) ? 1'b1 : w_eff_first;
        n_ramp_on   = w_first_now && (CMP_W'(w_eff_pos) < CMP_W'(i_cfg.ramp_samples));
        n_use_sine  = n_latched || n_ramp_on;

        if (i_cfg.samples_per_bit == '0) begin
            w_len = CMP_W'(1);
        end else if (CMP_W'(i_cfg.samples_per_bit) > CMP_W'(MAX_SYMBOL_SAMPLES)) begin
            w_len = CMP_W'(MAX_SYMBOL_SAMPLES);
        end else begin
            w_len = CMP_W'(i_cfg.samples_per_bit);
        end

        w_pos_next = CMP_W'(w_eff_pos) + CMP_W'(1);
        n_sym_end  = (w_pos_next >= w_len);
        n_pos      = n_sym_end ? '0 : w_pos_next[POS_W-1:0];
        n_first    = n_sym_end ? 1'b0 : w_first_now;
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_state = S_LUT;
                end
            end
            S_LUT: n_state = S_MUL;
            S_MUL: n_state = S_OUT;
            S_OUT: begin
                if (w_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd.start      = w_accept;
        o_cmd.zero_phase = w_sym_start && w_first_now;
        o_cmd.pos        = w_eff_pos;
        o_cmd.lut        = (r_state == S_LUT);
        o_cmd.ramp_on    = r_ramp_on;
        o_cmd.rise       = r_latched;
        o_cmd.mul        = (r_state == S_MUL);
        o_cmd.load_out   = (r_state == S_OUT) && w_out_free;
        o_cmd.use_sine   = r_use_sine;
        o_cmd.sym_end    = r_sym_end;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_pos       <= '0;
            r_latched   <= 1'b0;
            r_first     <= 1'b1;
            r_prev      <= 1'b0;
        end else begin
            r_state <= n_state;
            if (o_cmd.load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            if (w_accept) begin
                r_pos     <= n_pos;
                r_latched <= n_latched;
                r_first   <= n_first;
                r_prev    <= n_prev;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_ramp_on  <= n_ramp_on;
            r_use_sine <= n_use_sine;
            r_sym_end  <= n_sym_end;
        end
    end

    `CWKTG_ASSERT_NEXT(a_idle_holds, i_clk, i_rst_n, (r_state == S_IDLE) && !w_accept, r_state == S_IDLE, "sequencer left idle without an item")
    `CWKTG_ASSERT_NEXT(a_out_not_overrun, i_clk, i_rst_n, (r_state == S_OUT) && !w_out_free, (r_state == S_OUT) && r_out_valid, "result overwritten before taken")
    `CWKTG_ASSERT_NOW(a_mid_symbol_key, i_clk, i_rst_n, r_pos != '0, r_prev == r_latched, "key tracking diverged inside a symbol")

endmodule

>>> hw/rtl/cwktg_datapath.sv
`include "cw_keyed_tone_generator_assert.svh"

module cwktg_datapath (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  cwktg_pkg::t_cfg                  i_cfg,
    input  cwktg_pkg::t_dp_cmd               i_cmd,
    output logic [cwktg_pkg::SAMPLE_W-1:0]   o_sample,
    output logic                             o_symbol_end
);
    import cwktg_pkg::*;

    logic        [PHASE_W-1:0]             r_phase;
    logic        [PHASE_W-1:0]             r_cur_phase;
    logic        [RAMP_PROD_W-1:0]         r_ramp_prod;
    logic signed [SINE_W-1:0]              r_sine;
    logic        [GAIN_W-1:0]              r_gain;
    logic signed [PROD1_W-1:0]             r_prod1;
    logic        [SAMPLE_W-1:0]            r_sample;
    logic                                  r_sym_end;

    logic        [PHASE_W-1:0]             w_base;
    logic        [POS_W+RAMP_STEP_W-1:0]   w_ramp_full;
    logic        [PHASE_W-1:0]             w_cos_phase;
    logic signed [SINE_W-1:0]              w_cos;
    logic signed [SINE_W:0]                w_gain_num;
    logic signed [2*SINE_W-1:0]            w_p1;
    logic signed [VOLUME_W+PROD1_W:0]      w_v;

    assign w_base      = i_cmd.zero_phase ? '0 : r_phase;
    assign w_ramp_full = i_cmd.pos * i_cfg.ramp_step;
    assign w_cos_phase = {r_ramp_prod, RAMP_SHIFT'(0)} + QUARTER_PHASE;
    assign w_cos       = sine_q16(w_cos_phase);
    assign w_gain_num  = i_cmd.rise ? ((SINE_W+1)'(65536) - w_cos)
                                    : ((SINE_W+1)'(65536) + w_cos);
    assign w_p1        = $signed({1'b0, r_gain}) * r_sine;
    assign w_v         = $signed({1'b0, i_cfg.volume}) * r_prod1;

    assign o_sample     = r_sample;
    assign o_symbol_end = r_sym_end;

    // The running oscillator phase resets to zero.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= '0;
        end else if (i_cmd.start) begin
            r_phase <= w_base + i_cfg.phase_step;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_cur_phase <= w_base;
            r_ramp_prod <= w_ramp_full[RAMP_PROD_W-1:0];
        end
        if (i_cmd.lut) begin
            r_sine <= sine_q16(r_cur_phase);
            r_gain <= i_cmd.ramp_on ? w_gain_num[GAIN_W:1] : SINE_ONE;
        end
        if (i_cmd.mul) begin
            r_prod1 <= w_p1[PROD1_W-1:0];
        end
        if (i_cmd.load_out) begin
            r_sample  <= i_cmd.use_sine ? (w_v[PHASE_W+SAMPLE_W-1:PHASE_W] + SAMPLE_MID)
                                        : SAMPLE_MID;
            r_sym_end <= i_cmd.sym_end;
        end
    end

    `CWKTG_ASSERT_NEXT(a_full_gain, i_clk, i_rst_n, i_cmd.lut && !i_cmd.ramp_on, r_gain == SINE_ONE, "gain outside ramp is not unity")

endmodule

>>> hw/rtl/cw_keyed_tone_generator.sv
// The sequencer walks one item at a time through table lookup, two multiplies
// and output load, and takes no new item until the result is loaded.
// A result that is not taken holds the sequencer in its last step until taken.
// Reset (synchronous, active low) clears phase, symbol position and run tracking
// and loads the register defaults; no clearing pass is needed.
module cw_keyed_tone_generator (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    cwktg_key_if.sink                          i_key,
    cwktg_smp_if.source                        o_smp,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [cwktg_pkg::PADDR_W-1:0]      paddr,
    input  logic [cwktg_pkg::APB_DATA_W-1:0]   pwdata,
    output logic [cwktg_pkg::APB_DATA_W-1:0]   prdata,
    output logic                               pready
);
    import cwktg_pkg::*;

    // Each accepted item yields one audio sample. At the first sample of a
    // symbol the key is latched. The first tone symbol of a run restarts the
    // oscillator phase at zero and rises on a raised-cosine ramp; the first
    // silent symbol after tone falls on a ramp over a fresh sine, and later
    // silence is the midpoint 128.

    t_cfg    w_cfg;
    t_dp_cmd w_cmd;

    // Configuration registers behind the APB port.
    cwktg_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    // The sequencer owns symbol position, key latch and run tracking, and the
    // output valid flag. It issues one command per step to the datapath.
    cwktg_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (w_cfg),
        .i_in_valid  (i_key.valid),
        .o_in_ready  (i_key.ready),
        .i_key_down  (i_key.key_down),
        .i_restart   (i_key.restart),
        .o_out_valid (o_smp.valid),
        .i_out_ready (o_smp.ready),
        .o_cmd       (w_cmd)
    );

    // The datapath holds the oscillator phase, looks up the tone sine and the
    // ramp cosine in one shared quarter-wave table, forms the gain, and scales
    // the sine by gain and then by volume into the output register.
    cwktg_datapath u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (w_cfg),
        .i_cmd        (w_cmd),
        .o_sample     (o_smp.sample),
        .o_symbol_end (o_smp.symbol_end)
    );

endmodule

>>> test/tb.sv
`timescale 1ns / 1ps

import cwktg_pkg::*;

// One expected output sample of the tone generator.
typedef struct {
    logic [SAMPLE_W-1:0] sample;
    logic                symbol_end;
} tone_sample_t;

// Predicts the keyed tone sample by sample and checks what the block returns.
class tone_scoreboard;
    // Register copies.
    logic [PHASE_W-1:0]     phase_step;
    logic [VOLUME_W-1:0]    volume;
    logic [SPB_W-1:0]       samples_per_bit;
    logic [RAMP_LEN_W-1:0]  ramp_samples;
    logic [RAMP_STEP_W-1:0] ramp_step;

    // Keying state.
    logic [PHASE_W-1:0] tone_phase;
    logic [POS_W-1:0]   sample_position;
    logic               latched_key;
    logic               first_of_run;
    logic               previous_key;

    tone_sample_t expected_samples[$];
    int           errors;

    function new();
        phase_step      = '0;
        volume          = VOLUME_RST;
        samples_per_bit = SPB_RST;
        ramp_samples    = RAMP_LEN_RST;
        ramp_step       = RAMP_STEP_RST;
        tone_phase      = '0;
        sample_position = '0;
        latched_key     = 1'b0;
        first_of_run    = 1'b1;
        previous_key    = 1'b0;
        errors          = 0;
    endfunction

    function void write_reg(logic [REG_IDX_W-1:0] idx, logic [APB_DATA_W-1:0] value);
        case (idx)
            REG_PHASE_STEP:      phase_step      = value[PHASE_W-1:0];
            REG_VOLUME:          volume          = value[VOLUME_W-1:0];
            REG_SAMPLES_PER_BIT: samples_per_bit = value[SPB_W-1:0];
            REG_RAMP_SAMPLES:    ramp_samples    = value[RAMP_LEN_W-1:0];
            REG_RAMP_STEP:       ramp_step       = value[RAMP_STEP_W-1:0];
            default: ;
        endcase
    endfunction

    // Symbol length as the block uses it: zero acts as one, long values saturate.
    function int symbol_length();
        int len;
        len = int'(samples_per_bit);
        if (len == 0) begin
            len = 1;
        end
        if (len > MAX_SYMBOL_SAMPLES) begin
            len = MAX_SYMBOL_SAMPLES;
        end
        return len;
    endfunction

    // Q16 sine of a 0.32 cycle phase from the quarter-wave polynomial.
    function longint wave_q16(logic [PHASE_W-1:0] ph);
        logic [SINE_TABLE_BITS-1:0] idx;
        logic [1:0]                 quad;
        longint unsigned            t;
        longint unsigned            t2;
        longint unsigned            p;
        longint unsigned            m;
        idx  = ph[PHASE_W-1 -: SINE_TABLE_BITS];
        quad = idx[SINE_TABLE_BITS-1 -: 2];
        t    = longint'(idx[SINE_TABLE_BITS-3:0]) << (18 - SINE_TABLE_BITS);
        if (quad[0]) begin
            t = 64'd65536 - t;
        end
        t2 = (t * t) >> 16;
        p  = 64'd42048 - ((64'd4640 * t2) >> 16);
        p  = 64'd102944 - ((p * t2) >> 16);
        m  = (t * p) >> 16;
        if (m > 64'd65536) begin
            m = 64'd65536;
        end
        return quad[1] ? -longint'(m) : longint'(m);
    endfunction

    function void note_key(logic k, logic rs);
        int               len;
        logic [POS_W-1:0] pos;
        longint           gain;
        longint           c;
        longint           v;
        logic             use_sine;
        logic [63:0]      prod;
        logic [PHASE_W-1:0] ang;
        logic [63:0]      biased;
        tone_sample_t     item;
        if (rs) begin
            sample_position = '0;
            previous_key    = 1'b0;
            first_of_run    = 1'b1;
        end
        len = symbol_length();
        pos = sample_position;
        if (pos == '0) begin
            latched_key = k;
            if (k != previous_key) begin
                first_of_run = 1'b1;
            end
            previous_key = k;
            if (first_of_run) begin
                tone_phase = '0;
            end
        end
        gain     = 65536;
        use_sine = latched_key;
        if (first_of_run && (int'(pos) < int'(ramp_samples))) begin
            prod = 64'(pos) * 64'(ramp_step);
            ang  = PHASE_W'(prod << RAMP_SHIFT) + QUARTER_PHASE;
            c    = wave_q16(ang);
            gain = latched_key ? (65536 - c) / 2 : (65536 + c) / 2;
            use_sine = 1'b1;
        end
        if (use_sine) begin
            v           = longint'(volume) * gain * wave_q16(tone_phase);
            biased      = v + (longint'(128) << 32);
            item.sample = biased[39:32];
        end else begin
            item.sample = SAMPLE_MID;
        end
        tone_phase = tone_phase + phase_step;
        item.symbol_end = (int'(pos) + 1 >= len);
        if (item.symbol_end) begin
            sample_position = '0;
            first_of_run    = 1'b0;
        end else begin
            sample_position = pos + 1'b1;
        end
        expected_samples.push_back(item);
    endfunction

    function void check_sample(logic [SAMPLE_W-1:0] s, logic e);
        tone_sample_t want;
        if (expected_samples.size() == 0) begin
            $error("sample %0d arrived with no item waiting", s);
            errors++;
        end else begin
            want = expected_samples.pop_front();
            if (s !== want.sample) begin
                $error("sample: expected %0d, actual %0d", want.sample, s);
                errors++;
            end
            if (e !== want.symbol_end) begin
                $error("symbol_end: expected %0d, actual %0d", want.symbol_end, e);
                errors++;
            end
        end
    endfunction

    function int pending();
        return expected_samples.size();
    endfunction
endclass

module tb;

    // Cycles without any handshake or register access before the run is
    // declared hung. The slowest item costs a sender gap, a receiver stall
    // and the block's own sequencer pass, far below this.
    localparam int WATCHDOG_LIMIT = 2000;
    // Number of random phases; each one gets a fresh register setting.
    localparam int RANDOM_PHASES  = 14;
    localparam int PHASE_ITEMS    = 135;
    // An index past the register list, which the block must ignore.
    localparam logic [REG_IDX_W-1:0] REG_UNUSED = 3'd5;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [PADDR_W-1:0]    paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    cwktg_key_if key_bus ();
    cwktg_smp_if sample_bus ();

    tone_scoreboard sb;

    // When set, both sides insert random idle bursts.
    logic bursty;
    int   stall_left;

    cw_keyed_tone_generator dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_key   (key_bus),
        .o_smp   (sample_bus),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // Sample sink: ready drops in bursts of random length while idling is on.
    always @(posedge i_clk) begin
        if (stall_left != 0) begin
            stall_left       <= stall_left - 1;
            sample_bus.ready <= (stall_left == 1);
        end else if (bursty && ($urandom_range(0, 7) == 0)) begin
            sample_bus.ready <= 1'b0;
            stall_left       <= $urandom_range(1, 11);
        end else begin
            sample_bus.ready <= 1'b1;
        end
    end

    // Monitor: every handshake is sampled at the clock edge, before the
    // nonblocking updates of that edge land. Samples are checked against the
    // oldest expectation, and each accepted key item adds one expectation.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (sample_bus.valid && sample_bus.ready) begin
                sb.check_sample(sample_bus.sample, sample_bus.symbol_end);
            end
            if (key_bus.valid && key_bus.ready) begin
                sb.note_key(key_bus.key_down, key_bus.restart);
            end
        end
    end

    // Watchdog: ends the run if nothing moves for too long.
    initial begin
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if ((key_bus.valid && key_bus.ready) || (sample_bus.valid && sample_bus.ready)
                    || psel) begin
                quiet = 0;
            end else begin
                quiet++;
            end
        end
        $display("TEST FAILED");
        $finish;
    end

    // Offers one key item and holds it until the block takes it. With idling
    // on, a random gap may follow; otherwise valid stays high for the next item.
    task automatic send_key(logic k, logic rs);
        key_bus.valid    <= 1'b1;
        key_bus.key_down <= k;
        key_bus.restart  <= rs;
        do @(posedge i_clk); while (!key_bus.ready);
        if (bursty && ($urandom_range(0, 4) == 0)) begin
            key_bus.valid    <= 1'b0;
            key_bus.key_down <= 1'($urandom);
            key_bus.restart  <= 1'($urandom);
            repeat ($urandom_range(1, 11)) @(posedge i_clk);
        end
    endtask

    // Stops offering items and waits until every expected sample has come out.
    // The first edge lets the monitor note an item taken at the current edge.
    task automatic settle();
        key_bus.valid <= 1'b0;
        @(posedge i_clk);
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    // One APB write: setup cycle, access cycle, register loaded at the edge
    // where the access completes. The trailing edge keeps psel from being
    // lowered and raised in the same step by back-to-back writes.
    task automatic apb_write(logic [REG_IDX_W-1:0] idx, logic [APB_DATA_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        sb.write_reg(idx, value);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    // Writes a full register setting, only once the block has gone idle.
    task automatic configure(logic [31:0] ps, logic [31:0] vol, logic [31:0] spb,
                             logic [31:0] rlen, logic [31:0] rstep);
        settle();
        apb_write(REG_PHASE_STEP, ps);
        apb_write(REG_VOLUME, vol);
        apb_write(REG_SAMPLES_PER_BIT, spb);
        apb_write(REG_RAMP_SAMPLES, rlen);
        apb_write(REG_RAMP_STEP, rstep);
    endtask

    // Morse-like keying: the key level is held for stretches of about one to
    // three symbols and mostly alternates, so that tone runs start, continue
    // and end. A tenth of the items carry a random key, and a rare restart
    // begins a new message at an arbitrary point.
    task automatic play_keying(int n);
        int   hold_left;
        logic level;
        logic k;
        hold_left = 0;
        level     = 1'($urandom);
        for (int i = 0; i < n; i++) begin
            if (hold_left == 0) begin
                if ($urandom_range(0, 3) != 0) begin
                    level = ~level;
                end
                hold_left = $urandom_range(1, 3 * sb.symbol_length());
            end
            k = ($urandom_range(0, 9) == 0) ? 1'($urandom) : level;
            send_key(k, $urandom_range(0, 79) == 0);
            hold_left--;
        end
    endtask

    initial begin
        logic [31:0] ps;
        logic [31:0] vol;
        logic [31:0] spb;
        logic [31:0] rlen;
        logic [31:0] rstep;

        // Every input is known from time zero.
        sb                  = new();
        bursty              = 1'b1;
        stall_left          = 0;
        i_rst_n             = 1'b0;
        psel                = 1'b0;
        penable             = 1'b0;
        pwrite              = 1'b0;
        paddr               = '0;
        pwdata              = '0;
        key_bus.valid       = 1'b0;
        key_bus.key_down    = 1'b0;
        key_bus.restart     = 1'b0;
        sample_bus.ready    = 1'b0;

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset defaults: a silent first symbol with a falling ramp.
        send_key(1'b0, 1'b0);
        send_key(1'b1, 1'b0);

        // Three-sample symbols with a two-sample ramp and a quarter-cycle tone
        // step. The restart abandons the symbol still open from the defaults and
        // aligns the walk through: first silence with its fall, a rising tone run
        // that ignores key changes inside a symbol, a continued tone, the fall
        // after it, plain silence, and a restart in the middle of a symbol.
        configure(32'h4000_0000, 127, 3, 2, 32'h8000);
        send_key(1'b0, 1'b1);
        send_key(1'b0, 1'b0);
        send_key(1'b0, 1'b0);
        send_key(1'b1, 1'b0);
        send_key(1'b0, 1'b0);
        send_key(1'b0, 1'b0);
        send_key(1'b1, 1'b0);
        send_key(1'b1, 1'b0);
        send_key(1'b1, 1'b0);
        send_key(1'b0, 1'b0);
        send_key(1'b1, 1'b0);
        send_key(1'b1, 1'b0);
        send_key(1'b0, 1'b0);
        send_key(1'b0, 1'b0);
        send_key(1'b0, 1'b0);
        send_key(1'b1, 1'b0);
        send_key(1'b1, 1'b1);
        send_key(1'b1, 1'b0);

        // Zero symbol length acts as one, no ramp, silent volume, and the
        // largest phase and ramp steps. A write past the list is ignored.
        configure(32'hFFFF_FFFF, 0, 0, 0, 32'hFFFF);
        apb_write(REG_UNUSED, $urandom);
        send_key(1'b1, 1'b0);
        send_key(1'b0, 1'b0);
        send_key(1'b1, 1'b0);
        send_key(1'b1, 1'b1);

        // Random phases. Symbols are mostly short so that many of them pass;
        // a few use lengths at or past the maximum, where the ramp and the
        // first part of a symbol are what gets exercised. The last phase has
        // no idling on either side.
        for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
            case ($urandom_range(0, 7))
                0:       ps = '0;
                1:       ps = 32'hFFFF_FFFF;
                2:       ps = $urandom_range(1, 32'h0400_0000);
                default: ps = $urandom;
            endcase
            case ($urandom_range(0, 7))
                0:       vol = 0;
                1:       vol = 127;
                default: vol = $urandom_range(0, 127);
            endcase
            case ($urandom_range(0, 9))
                0: spb = 0;
                1: begin
                    case ($urandom_range(0, 3))
                        0:       spb = 1;
                        1:       spb = MAX_SYMBOL_SAMPLES;
                        2:       spb = MAX_SYMBOL_SAMPLES + 1;
                        default: spb = 13'h1FFF;
                    endcase
                end
                2:       spb = $urandom_range(25, 400);
                default: spb = $urandom_range(1, 24);
            endcase
            case ($urandom_range(0, 7))
                0:       rlen = 0;
                1:       rlen = $urandom_range(41, 63);
                2:       rlen = 40;
                default: rlen = $urandom_range(0, (spb < 40) ? spb + 2 : 40);
            endcase
            case ($urandom_range(0, 7))
                0:       rstep = 0;
                1:       rstep = 32'hFFFF;
                2:       rstep = $urandom_range(0, 32'hFFFF);
                default: rstep = (rlen == 0) ? 32'hFFFF : ((65536 / rlen > 65535) ? 65535
                                                            : 65536 / rlen);
            endcase
            configure(ps, vol, spb, rlen, rstep);
            bursty = (ph != RANDOM_PHASES - 1) && ($urandom_range(0, 4) != 0);
            play_keying(PHASE_ITEMS);
        end

        // Drain the last samples; the watchdog covers a block that hangs here.
        settle();
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

>>> filelist.f
+incdir+hw/rtl
hw/rtl/cwktg_pkg.sv
hw/rtl/cwktg_key_if.sv
hw/rtl/cwktg_smp_if.sv
hw/rtl/cwktg_regs.sv
hw/rtl/cwktg_ctrl.sv
hw/rtl/cwktg_datapath.sv
hw/rtl/cw_keyed_tone_generator.sv
test/tb.sv
